// File: src/mcci_pkg.sv
// Shared types, command codes and a helper function for the memory card command interface.
package mcci_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LEN_W   = 24;
    localparam int unsigned RAM_W   = 25;
    localparam int unsigned SIZE_W  = 6;
    localparam int unsigned CFG_W   = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned HALFMIB_SHIFT = 19;

    localparam logic [1:0] REQ_IMM_WRITE = 2'd0;
    localparam logic [1:0] REQ_IMM_READ  = 2'd1;
    localparam logic [1:0] REQ_DMA       = 2'd2;

    localparam logic [7:0] OP_IDENT      = 8'h00;
    localparam logic [7:0] OP_STATUS     = 8'h83;
    localparam logic [7:0] OP_STATUS_CLR = 8'h89;
    localparam logic [7:0] OP_BLOCK_RD   = 8'h52;
    localparam logic [7:0] OP_PAGE_WR    = 8'hF2;
    localparam logic [7:0] OP_SECTOR_ER  = 8'hF1;

    localparam logic [7:0] ST_READY    = 8'h01;
    localparam logic [7:0] ST_UNLOCKED = 8'h40;

    localparam logic [CFG_IDX_W-1:0] CFG_CARD_PRESENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_SIZE    = 1'd1;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_UNKNOWN_CMD = 3'd1,
        ERR_NO_COMMAND  = 3'd2,
        ERR_NO_CARD     = 3'd3,
        ERR_RANGE       = 3'd4
    } err_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] write_word;
        logic [LEN_W-1:0]  xfer_length;
        logic              to_card;
        logic [RAM_W-1:0]  ram_address;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        err_t              error_code;
        logic [WORD_W-1:0] dma_card_offset;
        logic [RAM_W-1:0]  dma_ram_address;
        logic [LEN_W-1:0]  dma_length;
        logic              dma_valid;
        logic              card_written;
    } res_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     wdata;
    } cfg_wr_t;

    function automatic logic [7:0] capacity_id(input logic present, input logic [SIZE_W-1:0] size);
        logic [7:0] id;
        id = 8'h00;
        if (present) begin
            case (size)
                6'd1:    id = 8'h04;
                6'd2:    id = 8'h08;
                6'd4:    id = 8'h10;
                6'd8:    id = 8'h20;
                6'd16:   id = 8'h40;
                6'd32:   id = 8'h80;
                default: id = 8'h00;
            endcase
        end
        return id;
    endfunction

endpackage

// File: src/mcci_in_reg.sv
// Input register stage holding one accepted request transaction.
module mcci_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mcci_pkg::req_t s_req,
    input  logic          advance,
    output logic          req_valid,
    output mcci_pkg::req_t req
);
    import mcci_pkg::*;

    logic valid_reg;
    req_t req_reg;

    assign s_ready   = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

endmodule

// File: src/mcci_exec.sv
// Command decode, card state and result formation for one request per cycle while step is high.
module mcci_exec (
    input  logic            aclk,
    input  logic            aresetn,
    input  mcci_pkg::cfg_wr_t cfg,
    input  mcci_pkg::req_t  req,
    input  logic            step,
    output mcci_pkg::res_t  res
);
    import mcci_pkg::*;

    logic              present_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [7:0]        cmd_reg, cmd_next;
    logic [WORD_W-1:0] addr_reg, addr_next;
    logic [7:0]        status_reg, status_next;
    logic              written_reg, written_next;

    logic [7:0]        id;
    logic [WORD_W:0]   end_addr;
    logic [WORD_W:0]   limit;

    assign id       = capacity_id(present_reg, size_reg);
    assign end_addr = {1'b0, addr_reg} + {{(WORD_W + 1 - LEN_W){1'b0}}, req.xfer_length};
    assign limit    = {{(WORD_W + 1 - SIZE_W - HALFMIB_SHIFT){1'b0}}, size_reg,
                       {HALFMIB_SHIFT{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            size_reg    <= 6'd1;
        end else if (cfg.we) begin
            case (cfg.index)
                CFG_CARD_PRESENT: present_reg <= cfg.wdata[0];
                CFG_CARD_SIZE:    size_reg    <= cfg.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg     <= OP_IDENT;
            addr_reg    <= '0;
            status_reg  <= ST_READY | ST_UNLOCKED;
            written_reg <= 1'b0;
        end else if (step) begin
            cmd_reg     <= cmd_next;
            addr_reg    <= addr_next;
            status_reg  <= status_next;
            written_reg <= written_next;
        end
    end

    always_comb begin
        res          = '0;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        status_next  = status_reg;
        written_next = written_reg;
        case (req.req_type)
            REQ_IMM_WRITE: begin
                if (cmd_reg == OP_BLOCK_RD && req.xfer_length <= 24'd4) begin
                    case (req.xfer_length[2:0])
                        3'd1: addr_next = {addr_reg[23:0], req.write_word[31:24]};
                        3'd2: addr_next = {addr_reg[15:0], req.write_word[31:16]};
                        3'd3: addr_next = {addr_reg[7:0], req.write_word[31:8]};
                        3'd4: addr_next = req.write_word;
                        default: ;
                    endcase
                end else begin
                    case (req.write_word[31:24])
                        OP_IDENT, OP_STATUS: begin
                            cmd_next = req.write_word[31:24];
                        end
                        OP_STATUS_CLR: begin
                            cmd_next    = req.write_word[31:24];
                            status_next = status_reg | ST_READY;
                        end
                        OP_BLOCK_RD, OP_PAGE_WR, OP_SECTOR_ER: begin
                            cmd_next  = req.write_word[31:24];
                            addr_next = {8'd0, req.write_word[23:0]};
                        end
                        default: res.error_code = ERR_UNKNOWN_CMD;
                    endcase
                end
            end
            REQ_IMM_READ: begin
                if (cmd_reg == OP_IDENT) begin
                    if (req.xfer_length >= 24'd4) begin
                        res.read_data = {24'd0, id};
                    end else begin
                        case (req.xfer_length[1:0])
                            2'd1:    res.read_data = {id, 24'd0};
                            2'd2:    res.read_data = {8'd0, id, 16'd0};
                            2'd3:    res.read_data = {16'd0, id, 8'd0};
                            default: res.read_data = '0;
                        endcase
                    end
                end else if (cmd_reg == OP_STATUS) begin
                    res.read_data = {status_reg, 24'd0};
                end else begin
                    res.error_code = ERR_NO_COMMAND;
                end
            end
            REQ_DMA: begin
                if (!present_reg) begin
                    res.error_code = ERR_NO_CARD;
                end else if (end_addr > limit) begin
                    res.error_code = ERR_RANGE;
                end else begin
                    res.dma_card_offset = addr_reg;
                    res.dma_ram_address = req.ram_address;
                    res.dma_length      = req.xfer_length;
                    res.dma_valid       = 1'b1;
                    addr_next           = end_addr[WORD_W-1:0];
                    if (req.to_card) begin
                        written_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.card_written = written_next;
    end

endmodule

// File: src/memory_card_command_interface_unit.sv
// Top level of the memory card command interface with its input and result registers.
// A transaction passes the input register, the single decode stage and the result register.
// Throughput: one transaction per cycle while m_ready does not stall the result register.
// Reset: synchronous active-low aresetn empties both stages and restores the card state.
// Reset state: no card, size one unit, command read ID, address zero, status 0x41.
module memory_card_command_interface_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mcci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcci_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [31:0]                   s_write_word,
    input  logic [23:0]                   s_xfer_length,
    input  logic                          s_to_card,
    input  logic [24:0]                   s_ram_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_read_data,
    output logic [2:0]                    m_error_code,
    output logic [31:0]                   m_dma_card_offset,
    output logic [24:0]                   m_dma_ram_address,
    output logic [23:0]                   m_dma_length,
    output logic                          m_dma_valid,
    output logic                          m_card_written
);
    import mcci_pkg::*;

    req_t    s_req;
    req_t    req;
    logic    req_valid;
    logic    advance;
    logic    step;
    cfg_wr_t cfg;
    res_t    res;
    logic    out_valid_reg;
    res_t    out_reg;

    assign s_req = '{req_type: s_req_type, write_word: s_write_word,
                     xfer_length: s_xfer_length, to_card: s_to_card,
                     ram_address: s_ram_address};
    assign cfg   = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

    assign advance = !out_valid_reg || m_ready;
    assign step    = req_valid && advance;

    mcci_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    mcci_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .req     (req),
        .step    (step),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_read_data       = out_reg.read_data;
    assign m_error_code      = out_reg.error_code;
    assign m_dma_card_offset = out_reg.dma_card_offset;
    assign m_dma_ram_address = out_reg.dma_ram_address;
    assign m_dma_length      = out_reg.dma_length;
    assign m_dma_valid       = out_reg.dma_valid;
    assign m_card_written    = out_reg.card_written;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dma_valid |-> m_error_code == ERR_OK)
        else $error("DMA transaction issued together with an error code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_card_written |=> !m_valid || m_card_written)
        else $error("Card written flag cleared without reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dma_valid |-> m_dma_length == '0 && m_dma_card_offset == '0)
        else $error("DMA fields set on a transaction that moves no data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_OK |-> m_read_data == '0)
        else $error("Read data returned on a failed transaction");

endmodule
